[src/bf3_pkg.sv]
// Shared constants and types for the 3x3 grayscale bilateral filter.
`default_nettype none
package bf3_pkg;

  localparam int unsigned PIXEL_BITS_DEF       = 8;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 15;
  localparam int unsigned WEIGHT_BITS          = 16;
  localparam int unsigned NUM_NEIGH            = 8;
  localparam int unsigned NUM_LUT              = NUM_NEIGH / 2;
  localparam int unsigned CFG_IDX_BITS         = 1;

  // Lane order: up_left, up, up_right, left, right, down_left, down, down_right.
  localparam logic [NUM_NEIGH-1:0] CORNER_LANES = 8'b1010_0101;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EDGE   = 1'b0,
    REG_CORNER = 1'b1
  } cfg_reg_e;

endpackage
`default_nettype wire

[src/bf3_range_lut.sv]
// One copy of the range weight table with two registered read ports.
`default_nettype none
module bf3_range_lut
  import bf3_pkg::*;
#(
  parameter int unsigned ADDR_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic                   we_i,
  input  wire logic [ADDR_BITS-1:0]   waddr_i,
  input  wire logic [WEIGHT_BITS-1:0] wdata_i,
  input  wire logic [ADDR_BITS-1:0]   raddr_a_i,
  input  wire logic [ADDR_BITS-1:0]   raddr_b_i,
  output logic      [WEIGHT_BITS-1:0] rdata_a_o,
  output logic      [WEIGHT_BITS-1:0] rdata_b_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [WEIGHT_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

[src/bf3_accum.sv]
// Weight, product and sum stages producing numerator and denominator.
`default_nettype none
module bf3_accum
  import bf3_pkg::*;
#(
  parameter int unsigned PIXEL_BITS       = PIXEL_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  localparam int unsigned WW = 2 * WEIGHT_BITS - WEIGHT_FRAC_BITS,
  localparam int unsigned DW = WW + 4,
  localparam int unsigned NW = DW + PIXEL_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire logic [PIXEL_BITS-1:0]  center_i,
  input  wire logic [PIXEL_BITS-1:0]  pix_i [NUM_NEIGH],
  input  wire logic [WEIGHT_BITS-1:0] rw_i [NUM_NEIGH],
  input  wire logic [WEIGHT_BITS-1:0] edge_i,
  input  wire logic [WEIGHT_BITS-1:0] corner_i,
  output logic                        vld_o,
  output logic      [NW-1:0]          num_o,
  output logic      [DW-1:0]          den_o
);

  localparam int unsigned PW = PIXEL_BITS + WW;

  logic                   s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic [PIXEL_BITS-1:0]  s2_c_q, s3_c_q, s4_c_q;
  logic [PIXEL_BITS-1:0]  s2_pix_q [NUM_NEIGH];
  logic [WW-1:0]          s2_w_q [NUM_NEIGH];
  logic [WW-1:0]          s3_w_q [NUM_NEIGH];
  logic [PW-1:0]          s3_p_q [NUM_NEIGH];
  logic [PW:0]            s4_np_q [NUM_LUT];
  logic [WW:0]            s4_dp_q [NUM_LUT];
  logic [2*WEIGHT_BITS-1:0] prod_d [NUM_NEIGH];
  logic [NW-1:0]          num_d;
  logic [DW-1:0]          den_d;

  always_comb begin
    for (int i = 0; i < NUM_NEIGH; i++) begin
      prod_d[i] = (2*WEIGHT_BITS)'(rw_i[i]) *
                  (2*WEIGHT_BITS)'(CORNER_LANES[i] ? corner_i : edge_i);
    end
  end

  always_comb begin
    num_d = NW'(s4_c_q) << WEIGHT_FRAC_BITS;
    den_d = DW'(1) << WEIGHT_FRAC_BITS;
    for (int j = 0; j < NUM_LUT; j++) begin
      num_d = num_d + NW'(s4_np_q[j]);
      den_d = den_d + DW'(s4_dp_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= vld_i;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_c_q <= center_i;
      s3_c_q <= s2_c_q;
      s4_c_q <= s3_c_q;
      for (int i = 0; i < NUM_NEIGH; i++) begin
        s2_pix_q[i] <= pix_i[i];
        s2_w_q[i]   <= prod_d[i][2*WEIGHT_BITS-1:WEIGHT_FRAC_BITS];
        s3_w_q[i]   <= s2_w_q[i];
        s3_p_q[i]   <= PW'(s2_pix_q[i]) * PW'(s2_w_q[i]);
      end
      for (int j = 0; j < NUM_LUT; j++) begin
        s4_np_q[j] <= (PW+1)'(s3_p_q[2*j]) + (PW+1)'(s3_p_q[2*j+1]);
        s4_dp_q[j] <= (WW+1)'(s3_w_q[2*j]) + (WW+1)'(s3_w_q[2*j+1]);
      end
      num_o <= num_d;
      den_o <= den_d;
    end
  end

  assign vld_o = s5_vld_q;

endmodule
`default_nettype wire

[src/bf3_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module bf3_divider
  import bf3_pkg::*;
#(
  parameter int unsigned PIXEL_BITS       = PIXEL_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  localparam int unsigned WW = 2 * WEIGHT_BITS - WEIGHT_FRAC_BITS,
  localparam int unsigned DW = WW + 4,
  localparam int unsigned NW = DW + PIXEL_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic [NW-1:0]         num_i,
  input  wire logic [DW-1:0]         den_i,
  output logic                       vld_o,
  output logic      [PIXEL_BITS-1:0] quot_o
);

  localparam int unsigned LAST = PIXEL_BITS - 1;

  logic                  vld_q [PIXEL_BITS];
  logic [NW-1:0]         rem_q [PIXEL_BITS];
  logic [DW-1:0]         den_q [PIXEL_BITS];
  logic [PIXEL_BITS-1:0] quot_q [PIXEL_BITS];

  for (genvar s = 0; s < PIXEL_BITS; s++) begin : g_stage
    logic                  vld_in;
    logic [NW-1:0]         rem_in;
    logic [DW-1:0]         den_in;
    logic [PIXEL_BITS-1:0] quot_in;
    logic [NW-1:0]         dsh;
    logic                  ge;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    assign dsh = NW'(den_in) << (PIXEL_BITS - 1 - s);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_in - dsh : rem_in;
        den_q[s]  <= den_in;
        quot_q[s] <= (quot_in << 1) | PIXEL_BITS'(ge);
      end
    end
  end

  assign vld_o  = vld_q[LAST];
  assign quot_o = quot_q[LAST];

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && en_i) |-> (den_i != '0))
    else $error("divider fed a zero denominator");

  a_num_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && en_i) |-> ((NW+1)'(num_i) < ((NW+1)'(den_i) << PIXEL_BITS)))
    else $error("quotient would overflow the pixel range");

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] |-> (rem_q[LAST] < NW'(den_q[LAST])))
    else $error("final remainder not below denominator");

endmodule
`default_nettype wire

[src/bilateral_filter_3x3_gray.sv]
// Top level of the 3x3 grayscale bilateral filter.
// Throughput: one window per cycle; the pipeline advances whenever the output is free or taken.
// Latency is set by one table read, four weight/sum stages and one divider stage per result bit.
// Reset clears the valid bits and both spatial weight registers.
// The range table is not cleared by reset; load every entry that a filter transaction reads.
`default_nettype none
module bilateral_filter_3x3_gray
  import bf3_pkg::*;
#(
  parameter int unsigned PIXEL_BITS       = PIXEL_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [WEIGHT_BITS-1:0]  cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    action_i,
  input  wire logic [PIXEL_BITS-1:0]   center_i,
  input  wire logic [PIXEL_BITS-1:0]   up_left_i,
  input  wire logic [PIXEL_BITS-1:0]   up_i,
  input  wire logic [PIXEL_BITS-1:0]   up_right_i,
  input  wire logic [PIXEL_BITS-1:0]   left_i,
  input  wire logic [PIXEL_BITS-1:0]   right_i,
  input  wire logic [PIXEL_BITS-1:0]   down_left_i,
  input  wire logic [PIXEL_BITS-1:0]   down_i,
  input  wire logic [PIXEL_BITS-1:0]   down_right_i,
  input  wire logic [PIXEL_BITS-1:0]   table_index_i,
  input  wire logic [WEIGHT_BITS-1:0]  table_weight_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [PIXEL_BITS-1:0]   filtered_o
);

  localparam int unsigned WW = 2 * WEIGHT_BITS - WEIGHT_FRAC_BITS;
  localparam int unsigned DW = WW + 4;
  localparam int unsigned NW = DW + PIXEL_BITS;

  logic                   en;
  logic                   accept;
  logic                   lut_we;
  logic [WEIGHT_BITS-1:0] edge_q, corner_q;
  logic                   s1_vld_q;
  logic [PIXEL_BITS-1:0]  s1_c_q;
  logic [PIXEL_BITS-1:0]  s1_pix_q [NUM_NEIGH];
  logic [PIXEL_BITS-1:0]  nb [NUM_NEIGH];
  logic [PIXEL_BITS-1:0]  diff [NUM_NEIGH];
  logic [WEIGHT_BITS-1:0] rw [NUM_NEIGH];
  logic                   acc_vld;
  logic [NW-1:0]          acc_num;
  logic [DW-1:0]          acc_den;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign lut_we     = accept && action_i;

  assign nb[0] = up_left_i;
  assign nb[1] = up_i;
  assign nb[2] = up_right_i;
  assign nb[3] = left_i;
  assign nb[4] = right_i;
  assign nb[5] = down_left_i;
  assign nb[6] = down_i;
  assign nb[7] = down_right_i;

  always_comb begin
    for (int i = 0; i < NUM_NEIGH; i++) begin
      diff[i] = (nb[i] > center_i) ? nb[i] - center_i : center_i - nb[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= '0;
      corner_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_EDGE:   edge_q   <= cfg_wdata_i;
        REG_CORNER: corner_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold the stage on stall; load transactions launch no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i && !action_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_c_q <= center_i;
      for (int i = 0; i < NUM_NEIGH; i++) begin
        s1_pix_q[i] <= nb[i];
      end
    end
  end

  for (genvar k = 0; k < NUM_LUT; k++) begin : g_lut
    bf3_range_lut #(
      .ADDR_BITS (PIXEL_BITS)
    ) u_lut (
      .clk_i     (clk_i),
      .en_i      (en),
      .we_i      (lut_we),
      .waddr_i   (table_index_i),
      .wdata_i   (table_weight_i),
      .raddr_a_i (diff[2*k]),
      .raddr_b_i (diff[2*k+1]),
      .rdata_a_o (rw[2*k]),
      .rdata_b_o (rw[2*k+1])
    );
  end

  bf3_accum #(
    .PIXEL_BITS       (PIXEL_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s1_vld_q),
    .center_i (s1_c_q),
    .pix_i    (s1_pix_q),
    .rw_i     (rw),
    .edge_i   (edge_q),
    .corner_i (corner_q),
    .vld_o    (acc_vld),
    .num_o    (acc_num),
    .den_o    (acc_den)
  );

  bf3_divider #(
    .PIXEL_BITS       (PIXEL_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (acc_vld),
    .num_i  (acc_num),
    .den_i  (acc_den),
    .vld_o  (out_valid_o),
    .quot_o (filtered_o)
  );

endmodule
`default_nettype wire
